[hdl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the tile scroll sequencer
// Action and command codes, direction bits, control word layout and the
// microcode ROM.
// ----------------------------------------------------------------------------
package tss_pkg;

   // Input actions; they double as the microcode entry addresses
   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_START   = 2'd1,
      ACT_FINISH  = 2'd2,
      ACT_REFRESH = 2'd3
   } action_type;

   // Phase commands handed to the consumer
   typedef enum logic [2:0] {
      CMD_NONE        = 3'd0,
      CMD_MOVE_SCREEN = 3'd1,
      CMD_MOVE_COLOUR = 3'd2,
      CMD_DRAW_EDGES  = 3'd3,
      CMD_COPY_SPRITE = 3'd4,
      CMD_SWAP        = 3'd5,
      CMD_REDRAW      = 3'd6
   } cmd_type;

   // Direction bit positions
   localparam int DIR_LEFT  = 0;
   localparam int DIR_RIGHT = 1;
   localparam int DIR_UP    = 2;
   localparam int DIR_DOWN  = 3;

   // Phase counter values
   localparam logic [3:0] PHASE_FULL   = 4'd8;
   localparam logic [3:0] PHASE_NUDGE  = 4'd4;
   localparam logic [3:0] PHASE_SCREEN = 4'd7;
   localparam logic [3:0] PHASE_COLOUR = 4'd6;
   localparam logic [3:0] PHASE_EDGES  = 4'd5;
   localparam logic [3:0] PHASE_SPRITE = 4'd4;
   localparam logic [3:0] PHASE_SWAP   = 4'd3;

   // Fine scroll terms: (count - LEAD) & 7 and (TRAIL - count) & 7
   localparam logic [3:0] FINE_LEAD  = 4'd5;
   localparam logic [3:0] FINE_TRAIL = 4'd12;
   localparam logic [2:0] FINE_RESET = 3'd3;

   // Sprite nudge sizes
   localparam logic [4:0] NUDGE_TICK   = 5'd1;
   localparam logic [4:0] NUDGE_FINISH = 5'd8;

   // Datapath operation of one microcode step
   typedef enum logic [1:0] {
      OP_STEP    = 2'd0,
      OP_START   = 2'd1,
      OP_REFRESH = 2'd2,
      OP_HOLD    = 2'd3
   } op_type;

   // Sprite nudge select
   typedef enum logic [1:0] {
      NUD_NONE  = 2'd0,
      NUD_TICK  = 2'd1,
      NUD_PHASE = 2'd2
   } nudge_type;

   // Sequencing after the step
   typedef enum logic {
      JMP_DONE = 1'b0,
      JMP_BUSY = 1'b1
   } jump_type;

   typedef struct packed {
      op_type     op;
      nudge_type  nudge;
      jump_type   jump;
      logic [1:0] target;
   } ctrl_word_type;

   // Microcode ROM: one word per action, the finish word loops on itself
   function automatic ctrl_word_type ucode_rom(input logic [1:0] addr);
      ctrl_word_type w;
      w = '{op: OP_HOLD, nudge: NUD_NONE, jump: JMP_DONE, target: ACT_TICK};
      case (addr)
         ACT_TICK:    w = '{op: OP_STEP, nudge: NUD_TICK, jump: JMP_DONE,
                            target: ACT_TICK};
         ACT_START:   w = '{op: OP_START, nudge: NUD_NONE, jump: JMP_DONE,
                            target: ACT_TICK};
         ACT_FINISH:  w = '{op: OP_STEP, nudge: NUD_PHASE, jump: JMP_BUSY,
                            target: ACT_FINISH};
         ACT_REFRESH: w = '{op: OP_REFRESH, nudge: NUD_NONE, jump: JMP_DONE,
                            target: ACT_TICK};
         default:     w = '{op: OP_HOLD, nudge: NUD_NONE, jump: JMP_DONE,
                            target: ACT_TICK};
      endcase
      return w;
   endfunction

endpackage

[hdl/tss_if.sv]
// ----------------------------------------------------------------------------
// tss_if: request and response channels of the tile scroll sequencer
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface tss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [3:0] direction;

   modport source (output valid, action, direction, input ready);
   modport sink   (input valid, action, direction, output ready);
endinterface

interface tss_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         fine_x;
   logic [2:0]         fine_y;
   logic signed [15:0] pixel_off_x;
   logic signed [15:0] pixel_off_y;
   logic [7:0]         cell_origin_x;
   logic [7:0]         cell_origin_y;
   logic [2:0]         phase_cmd;
   logic               shown_buffer;
   logic signed [4:0]  sprite_dx;
   logic signed [4:0]  sprite_dy;
   logic [1:0]         fine_fix;
   logic               last;

   modport source (output valid, fine_x, fine_y, pixel_off_x, pixel_off_y,
                   cell_origin_x, cell_origin_y, phase_cmd, shown_buffer,
                   sprite_dx, sprite_dy, fine_fix, last,
                   input ready);
   modport sink   (input valid, fine_x, fine_y, pixel_off_x, pixel_off_y,
                   cell_origin_x, cell_origin_y, phase_cmd, shown_buffer,
                   sprite_dx, sprite_dy, fine_fix, last,
                   output ready);
endinterface

[hdl/tile_scroll_sequencer.sv]
// ----------------------------------------------------------------------------
// tile_scroll_sequencer: eight-phase double-buffered scroll sequencer
// First result is registered by the first step after the request transaction; a finish
// gives up to eight results, one per cycle while the response side is ready.
// Next request is taken the cycle after the last result is loaded.
// Synchronous reset: idle, fine values 3, buffer B shown, control and state 0.
// ----------------------------------------------------------------------------
module tile_scroll_sequencer
   import tss_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   tss_req_if.sink        req,
   tss_rsp_if.source      rsp
);

   // Sequencer control
   logic          run_ff, run_in;
   logic [1:0]    upc_ff, upc_in;
   logic [3:0]    dir_req_ff, dir_req_in;
   ctrl_word_type cw;
   logic          slot_free;
   logic          exec;
   logic          loop_again;

   // Architectural state
   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  dir_ff, dir_in;
   logic [2:0]  fx_ff, fx_in;
   logic [2:0]  fy_ff, fy_in;
   logic [15:0] px_ff, px_in;
   logic [15:0] py_ff, py_in;
   logic [7:0]  ox_ff, ox_in;
   logic [7:0]  oy_ff, oy_in;
   logic        vis_ff, vis_in;
   logic [1:0]  fix_ff, fix_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   cmd_type     cmd;
   logic [4:0]  delta;
   logic [4:0]  dx, dy;
   logic [2:0]  fine_lead, fine_trail;
   logic [3:0]  phase_dec;
   logic        busy;

   logic [2:0]  r_fx_ff, r_fy_ff;
   logic [15:0] r_px_ff, r_py_ff;
   logic [7:0]  r_ox_ff, r_oy_ff;
   cmd_type     r_cmd_ff;
   logic        r_vis_ff;
   logic [4:0]  r_dx_ff, r_dy_ff;
   logic [1:0]  r_fix_ff;
   logic        r_last_ff;

   // Handshake and microcode fetch
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign exec      = run_ff && slot_free;
   assign req.ready = !run_ff;
   assign cw        = ucode_rom(upc_ff);

   assign busy       = (phase_ff != 4'd0);
   assign phase_dec  = phase_ff - 4'd1;
   assign fine_lead  = 3'(phase_ff - FINE_LEAD);
   assign fine_trail = 3'(FINE_TRAIL - phase_ff);

   // Datapath: one control word step
   always_comb begin
      phase_in = phase_ff;
      dir_in   = dir_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      vis_in   = vis_ff;
      fix_in   = fix_ff;
      cmd      = CMD_NONE;
      dx       = 5'd0;
      dy       = 5'd0;

      // nudge size for this step
      case (cw.nudge)
         NUD_TICK:  delta = NUDGE_TICK;
         NUD_PHASE: delta = (phase_ff == PHASE_NUDGE) ? NUDGE_FINISH : 5'd0;
         default:   delta = 5'd0;
      endcase

      case (cw.op)
         OP_STEP: begin
            if (busy) begin
               // pixel offsets and fine scroll; right and down win the fine and nudge terms
               if (dir_ff[DIR_LEFT]) begin
                  px_in = px_in - 16'd1;
                  fx_in = fine_lead;
                  dx    = 5'd0 - delta;
               end
               if (dir_ff[DIR_RIGHT]) begin
                  px_in = px_in + 16'd1;
                  fx_in = fine_trail;
                  dx    = delta;
               end
               if (dir_ff[DIR_UP]) begin
                  py_in = py_in - 16'd1;
                  fy_in = fine_lead;
                  dy    = 5'd0 - delta;
               end
               if (dir_ff[DIR_DOWN]) begin
                  py_in = py_in + 16'd1;
                  fy_in = fine_trail;
                  dy    = delta;
               end

               // phase work selected by the decremented counter
               phase_in = phase_dec;
               case (phase_dec)
                  PHASE_SCREEN: cmd = CMD_MOVE_SCREEN;
                  PHASE_COLOUR: cmd = CMD_MOVE_COLOUR;
                  PHASE_EDGES: begin
                     cmd = CMD_DRAW_EDGES;
                     if (dir_ff[DIR_UP])    oy_in = oy_in + 8'd1;
                     if (dir_ff[DIR_DOWN])  oy_in = oy_in - 8'd1;
                     if (dir_ff[DIR_LEFT])  ox_in = ox_in + 8'd1;
                     if (dir_ff[DIR_RIGHT]) ox_in = ox_in - 8'd1;
                  end
                  PHASE_SPRITE: cmd = CMD_COPY_SPRITE;
                  PHASE_SWAP: begin
                     cmd    = CMD_SWAP;
                     vis_in = !vis_ff;
                  end
                  default: cmd = CMD_NONE;
               endcase
            end
         end
         OP_START: begin
            if (!busy && (dir_req_ff != 4'd0)) begin
               dir_in   = dir_req_ff;
               phase_in = PHASE_FULL;
               if (dir_req_ff[DIR_LEFT])       fix_in[0] = 1'b1;
               else if (dir_req_ff[DIR_RIGHT]) fix_in[0] = 1'b0;
               if (dir_req_ff[DIR_UP])         fix_in[1] = 1'b1;
               else if (dir_req_ff[DIR_DOWN])  fix_in[1] = 1'b0;
            end
         end
         OP_REFRESH: begin
            cmd      = CMD_REDRAW;
            vis_in   = !vis_ff;
            dir_in   = 4'd0;
            phase_in = 4'd0;
            fx_in    = FINE_RESET;
            fy_in    = FINE_RESET;
         end
         default: begin
            cmd = CMD_NONE;
         end
      endcase
   end

   // Sequencing: a finish loops while phases remain
   assign loop_again = (cw.jump == JMP_BUSY) && (phase_in != 4'd0);

   always_comb begin
      run_in     = run_ff;
      upc_in     = upc_ff;
      dir_req_in = dir_req_ff;
      if (req.valid && req.ready) begin
         run_in     = 1'b1;
         upc_in     = req.action;
         dir_req_in = req.direction;
      end else if (exec) begin
         run_in = loop_again;
         upc_in = cw.target;
      end
      rsp_valid_in = exec ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         upc_ff       <= ACT_TICK;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 4'd0;
         dir_ff       <= 4'd0;
         fx_ff        <= FINE_RESET;
         fy_ff        <= FINE_RESET;
         px_ff        <= 16'd0;
         py_ff        <= 16'd0;
         ox_ff        <= 8'd0;
         oy_ff        <= 8'd0;
         vis_ff       <= 1'b1;
         fix_ff       <= 2'd0;
      end else begin
         run_ff       <= run_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            phase_ff <= phase_in;
            dir_ff   <= dir_in;
            fx_ff    <= fx_in;
            fy_ff    <= fy_in;
            px_ff    <= px_in;
            py_ff    <= py_in;
            ox_ff    <= ox_in;
            oy_ff    <= oy_in;
            vis_ff   <= vis_in;
            fix_ff   <= fix_in;
         end
      end
   end

   // Request payload and response payload
   always_ff @(posedge clock) begin
      dir_req_ff <= dir_req_in;
      if (exec) begin
         r_fx_ff   <= fx_in;
         r_fy_ff   <= fy_in;
         r_px_ff   <= px_in;
         r_py_ff   <= py_in;
         r_ox_ff   <= ox_in;
         r_oy_ff   <= oy_in;
         r_cmd_ff  <= cmd;
         r_vis_ff  <= vis_in;
         r_dx_ff   <= dx;
         r_dy_ff   <= dy;
         r_fix_ff  <= fix_in;
         r_last_ff <= !loop_again;
      end
   end

   // Response channel
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.fine_x        = r_fx_ff;
   assign rsp.fine_y        = r_fy_ff;
   assign rsp.pixel_off_x   = $signed(r_px_ff);
   assign rsp.pixel_off_y   = $signed(r_py_ff);
   assign rsp.cell_origin_x = r_ox_ff;
   assign rsp.cell_origin_y = r_oy_ff;
   assign rsp.phase_cmd     = r_cmd_ff;
   assign rsp.shown_buffer  = r_vis_ff;
   assign rsp.sprite_dx     = $signed(r_dx_ff);
   assign rsp.sprite_dy     = $signed(r_dy_ff);
   assign rsp.fine_fix      = r_fix_ff;
   assign rsp.last          = r_last_ff;

`ifndef SYNTH
   // phase counter stays within the eight-phase range
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_FULL)
      else $error("phase counter out of range");

   // phase only counts down by one, loads eight, or clears
   a_phase_move: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != $past(phase_ff)) |->
         (phase_ff == $past(phase_ff) - 4'd1) ||
         (phase_ff == PHASE_FULL && $past(phase_ff) == 4'd0) ||
         (phase_ff == 4'd0))
      else $error("illegal phase counter move");

   // the sequencer finishes a transaction only after loading its last result
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(run_ff) && !$past(reset)) |-> (rsp_valid_ff && r_last_ff))
      else $error("sequencer ended without a last result");
`endif

endmodule
